// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in pipeline control");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in pipeline control");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/hsv_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv_pkg
// shared types and constants of the hsv to rgb converter pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package hsv_pkg;

  // channel format: unsigned fixed point, one = 1 << CHANNEL_FRAC_BITS
  localparam int CHANNEL_FRAC_BITS = 15;
  localparam int CHAN_W            = 16;
  localparam int CHAN_ONE          = 1 << CHANNEL_FRAC_BITS;

  // hue in 1/64 degree units
  localparam int HUE_W         = 16;
  localparam int HUE_FULL_TURN = 23040;
  localparam int HUE_SECTOR    = 3840;
  localparam int HMOD_W        = 15;
  localparam int REM_W         = 12;

  // sector size = 2^SECTOR_SH * SECTOR_ODD, division by the odd part by reciprocal
  localparam int SECTOR_SH   = 8;
  localparam int SECTOR_ODD  = 15;
  localparam int PROD_F_W    = CHAN_W + REM_W;
  localparam int Y_W         = 19;
  localparam int RECIP_SH    = 19;
  localparam int RECIP_W     = 16;
  localparam int RECIP_VAL   = (1 << RECIP_SH) / SECTOR_ODD;

  // pipeline stages
  localparam int NUM_STAGES = 7;
  localparam int STG_HUE    = 0;  // hue reduction and clamping
  localparam int STG_SECT   = 1;  // sector split and v(1-s)
  localparam int STG_SPROD  = 2;  // saturation times fraction
  localparam int STG_EST    = 3;  // reciprocal estimate
  localparam int STG_FIX    = 4;  // quotient correction
  localparam int STG_VMUL   = 5;  // v(1-sf) and v(1-s(1-f))
  localparam int STG_ROUTE  = 6;  // channel routing, output register

  // 60 degree sectors
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  // stage load enables from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/hsv_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// hsv_pipe_ctrl
// valid bits and per-stage load enables, bubbles collapse under stall
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hsv_pipe_ctrl
  import hsv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output pipe_ctl_t      ctl
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES-1:0] vld_up;

  // a stage can take a transfer when empty or when it drains this cycle
  always_comb begin
    rdy[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  // valid of the stage upstream of each register
  assign vld_up = {vld_r[NUM_STAGES-2:0], in_valid};

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      vld_nxt[k] = rdy[k] ? vld_up[k] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // outputs
  assign ctl.load  = rdy[NUM_STAGES-1:0] & vld_up;
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // input only stalls when every stage holds an item
  `ASSERT_SAME(a_stall_only_full, clk, rst_n, !rdy[0], &vld_r)
  // an accepted transfer lands in the first stage
  `ASSERT_NEXT(a_accept_lands, clk, rst_n, in_valid && rdy[0], vld_r[0])
  // a bubble behind a drained output reaches the output
  `ASSERT_NEXT(a_bubble_moves, clk, rst_n,
               out_ready && vld_r[NUM_STAGES-1] && !vld_r[NUM_STAGES-2],
               !vld_r[NUM_STAGES-1])

endmodule

`default_nettype wire

// ----- rtl/hsv_front.sv -----
// ----------------------------------------------------------------------------
// hsv_front
// hue reduction modulo a full turn, clamping, sector split and v(1-s)
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_front
  import hsv_pkg::*;
(
  input  wire logic                clk,
  input  wire pipe_ctl_t           ctl,
  input  wire logic [HUE_W-1:0]    hue,
  input  wire logic [CHAN_W-1:0]   saturation,
  input  wire logic [CHAN_W-1:0]   brightness,
  output sector_t                  sector,
  output logic [REM_W-1:0]         rem,
  output logic [CHAN_W-1:0]        sat,
  output logic [CHAN_W-1:0]        val,
  output logic [CHAN_W-1:0]        pv
);

  logic [HMOD_W-1:0]  h1_r, h1_nxt;
  logic [CHAN_W-1:0]  s1_r, s1_nxt;
  logic [CHAN_W-1:0]  v1_r, v1_nxt;
  logic [HUE_W-1:0]   hsub;

  sector_t            sec2_r, sec2_nxt;
  logic [REM_W-1:0]   rem2_r, rem2_nxt;
  logic [CHAN_W-1:0]  s2_r, v2_r, pv2_r, pv2_nxt;
  logic [HMOD_W-1:0]  rsub;
  logic [CHAN_W-1:0]  one_minus_s;
  logic [2*CHAN_W-1:0] pv_prod;

  // hue below three full turns: subtract zero, one or two turns
  always_comb begin
    if (hue >= HUE_W'(2 * HUE_FULL_TURN)) begin
      hsub = hue - HUE_W'(2 * HUE_FULL_TURN);
    end else if (hue >= HUE_W'(HUE_FULL_TURN)) begin
      hsub = hue - HUE_W'(HUE_FULL_TURN);
    end else begin
      hsub = hue;
    end
    h1_nxt = hsub[HMOD_W-1:0];
  end

  // saturation and value limited to one
  assign s1_nxt = (saturation > CHAN_W'(CHAN_ONE)) ? CHAN_W'(CHAN_ONE) : saturation;
  assign v1_nxt = (brightness > CHAN_W'(CHAN_ONE)) ? CHAN_W'(CHAN_ONE) : brightness;

  always_ff @(posedge clk) begin
    if (ctl.load[STG_HUE]) begin
      h1_r <= h1_nxt;
      s1_r <= s1_nxt;
      v1_r <= v1_nxt;
    end
  end

  // sector by threshold compare, remainder within the sector
  always_comb begin
    if (h1_r >= HMOD_W'(5 * HUE_SECTOR)) begin
      sec2_nxt = SEC_MAGENTA;
      rsub     = h1_r - HMOD_W'(5 * HUE_SECTOR);
    end else if (h1_r >= HMOD_W'(4 * HUE_SECTOR)) begin
      sec2_nxt = SEC_BLUE;
      rsub     = h1_r - HMOD_W'(4 * HUE_SECTOR);
    end else if (h1_r >= HMOD_W'(3 * HUE_SECTOR)) begin
      sec2_nxt = SEC_CYAN;
      rsub     = h1_r - HMOD_W'(3 * HUE_SECTOR);
    end else if (h1_r >= HMOD_W'(2 * HUE_SECTOR)) begin
      sec2_nxt = SEC_GREEN;
      rsub     = h1_r - HMOD_W'(2 * HUE_SECTOR);
    end else if (h1_r >= HMOD_W'(HUE_SECTOR)) begin
      sec2_nxt = SEC_YELLOW;
      rsub     = h1_r - HMOD_W'(HUE_SECTOR);
    end else begin
      sec2_nxt = SEC_RED;
      rsub     = h1_r;
    end
    rem2_nxt = rsub[REM_W-1:0];
  end

  // p = v(1-s), truncated
  assign one_minus_s = CHAN_W'(CHAN_ONE) - s1_r;
  assign pv_prod     = (2*CHAN_W)'(v1_r) * (2*CHAN_W)'(one_minus_s);
  assign pv2_nxt     = pv_prod[CHANNEL_FRAC_BITS +: CHAN_W];

  always_ff @(posedge clk) begin
    if (ctl.load[STG_SECT]) begin
      sec2_r <= sec2_nxt;
      rem2_r <= rem2_nxt;
      s2_r   <= s1_r;
      v2_r   <= v1_r;
      pv2_r  <= pv2_nxt;
    end
  end

  assign sector = sec2_r;
  assign rem    = rem2_r;
  assign sat    = s2_r;
  assign val    = v2_r;
  assign pv     = pv2_r;

endmodule

`default_nettype wire

// ----- rtl/hsv_frac_div.sv -----
// ----------------------------------------------------------------------------
// hsv_frac_div
// sf = floor(s*r/3840) and sg = floor(s*(3840-r)/3840) over three stages
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_frac_div
  import hsv_pkg::*;
(
  input  wire logic               clk,
  input  wire pipe_ctl_t          ctl,
  input  wire sector_t            sector_in,
  input  wire logic [REM_W-1:0]   rem,
  input  wire logic [CHAN_W-1:0]  sat,
  input  wire logic [CHAN_W-1:0]  val_in,
  input  wire logic [CHAN_W-1:0]  pv_in,
  output sector_t                 sector_out,
  output logic [CHAN_W-1:0]       val_out,
  output logic [CHAN_W-1:0]       pv_out,
  output logic [CHAN_W-1:0]       sf,
  output logic [CHAN_W-1:0]       sg
);

  localparam int EST_PROD_W = Y_W + RECIP_W;
  localparam int FIX_W      = Y_W + 1;

  // reciprocal estimate of y / SECTOR_ODD, low by at most one
  function automatic logic [RECIP_W-1:0] div_est(input logic [Y_W-1:0] y);
    logic [EST_PROD_W-1:0] prod;
    prod = EST_PROD_W'(y) * EST_PROD_W'(RECIP_VAL);
    return prod[RECIP_SH +: RECIP_W];
  endfunction

  // one compare and add corrects the estimate
  function automatic logic [CHAN_W-1:0] div_fix(input logic [Y_W-1:0] y,
                                                input logic [RECIP_W-1:0] est);
    logic [FIX_W-1:0] times15;
    logic [FIX_W-1:0] left;
    times15 = (FIX_W'(est) << 4) - FIX_W'(est);
    left    = FIX_W'(y) - times15;
    return (left >= FIX_W'(SECTOR_ODD)) ? CHAN_W'(est) + CHAN_W'(1) : CHAN_W'(est);
  endfunction

  logic [REM_W-1:0]     rem_c;
  logic [PROD_F_W-1:0]  prod_f, prod_g;

  logic [Y_W-1:0]       yf3_r, yg3_r;
  sector_t              sec3_r, sec4_r, sec5_r;
  logic [CHAN_W-1:0]    v3_r, v4_r, v5_r;
  logic [CHAN_W-1:0]    pv3_r, pv4_r, pv5_r;
  logic [Y_W-1:0]       yf4_r, yg4_r;
  logic [RECIP_W-1:0]   ef4_r, eg4_r;
  logic [CHAN_W-1:0]    sf5_r, sg5_r;

  // saturation times remainder and its complement, pre-shifted by the power of two
  assign rem_c  = REM_W'(HUE_SECTOR) - rem;
  assign prod_f = PROD_F_W'(sat) * PROD_F_W'(rem);
  assign prod_g = PROD_F_W'(sat) * PROD_F_W'(rem_c);

  always_ff @(posedge clk) begin
    if (ctl.load[STG_SPROD]) begin
      yf3_r  <= prod_f[SECTOR_SH +: Y_W];
      yg3_r  <= prod_g[SECTOR_SH +: Y_W];
      sec3_r <= sector_in;
      v3_r   <= val_in;
      pv3_r  <= pv_in;
    end
  end

  // reciprocal multiply
  always_ff @(posedge clk) begin
    if (ctl.load[STG_EST]) begin
      ef4_r  <= div_est(yf3_r);
      eg4_r  <= div_est(yg3_r);
      yf4_r  <= yf3_r;
      yg4_r  <= yg3_r;
      sec4_r <= sec3_r;
      v4_r   <= v3_r;
      pv4_r  <= pv3_r;
    end
  end

  // correction step
  always_ff @(posedge clk) begin
    if (ctl.load[STG_FIX]) begin
      sf5_r  <= div_fix(yf4_r, ef4_r);
      sg5_r  <= div_fix(yg4_r, eg4_r);
      sec5_r <= sec4_r;
      v5_r   <= v4_r;
      pv5_r  <= pv4_r;
    end
  end

  assign sector_out = sec5_r;
  assign val_out    = v5_r;
  assign pv_out     = pv5_r;
  assign sf         = sf5_r;
  assign sg         = sg5_r;

endmodule

`default_nettype wire

// ----- rtl/hsv_chan_out.sv -----
// ----------------------------------------------------------------------------
// hsv_chan_out
// q = v(1-sf), t = v(1-sg) and routing of v, p, q, t by sector
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_chan_out
  import hsv_pkg::*;
(
  input  wire logic               clk,
  input  wire pipe_ctl_t          ctl,
  input  wire sector_t            sector,
  input  wire logic [CHAN_W-1:0]  val,
  input  wire logic [CHAN_W-1:0]  pv,
  input  wire logic [CHAN_W-1:0]  sf,
  input  wire logic [CHAN_W-1:0]  sg,
  output logic [CHAN_W-1:0]       red,
  output logic [CHAN_W-1:0]       green,
  output logic [CHAN_W-1:0]       blue
);

  logic [CHAN_W-1:0]   one_minus_f, one_minus_g;
  logic [2*CHAN_W-1:0] q_prod, t_prod;

  sector_t             sec6_r;
  logic [CHAN_W-1:0]   v6_r, pv6_r, qv6_r, tv6_r;
  logic [CHAN_W-1:0]   red_r, green_r, blue_r;
  logic [CHAN_W-1:0]   red_nxt, green_nxt, blue_nxt;

  // value scaling, truncated
  assign one_minus_f = CHAN_W'(CHAN_ONE) - sf;
  assign one_minus_g = CHAN_W'(CHAN_ONE) - sg;
  assign q_prod      = (2*CHAN_W)'(val) * (2*CHAN_W)'(one_minus_f);
  assign t_prod      = (2*CHAN_W)'(val) * (2*CHAN_W)'(one_minus_g);

  always_ff @(posedge clk) begin
    if (ctl.load[STG_VMUL]) begin
      qv6_r  <= q_prod[CHANNEL_FRAC_BITS +: CHAN_W];
      tv6_r  <= t_prod[CHANNEL_FRAC_BITS +: CHAN_W];
      sec6_r <= sector;
      v6_r   <= val;
      pv6_r  <= pv;
    end
  end

  // sector routing; zero value and zero saturation fall out of the products
  always_comb begin
    case (sec6_r)
      SEC_RED: begin
        red_nxt = v6_r;  green_nxt = tv6_r; blue_nxt = pv6_r;
      end
      SEC_YELLOW: begin
        red_nxt = qv6_r; green_nxt = v6_r;  blue_nxt = pv6_r;
      end
      SEC_GREEN: begin
        red_nxt = pv6_r; green_nxt = v6_r;  blue_nxt = tv6_r;
      end
      SEC_CYAN: begin
        red_nxt = pv6_r; green_nxt = qv6_r; blue_nxt = v6_r;
      end
      SEC_BLUE: begin
        red_nxt = tv6_r; green_nxt = pv6_r; blue_nxt = v6_r;
      end
      default: begin
        red_nxt = v6_r;  green_nxt = pv6_r; blue_nxt = qv6_r;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.load[STG_ROUTE]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

`default_nettype wire

// ----- rtl/hsv_to_rgb_converter_top.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// hsv to rgb colour conversion, seven stage pipeline, with no output stall, one pixel per clock
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_*      slave      in_tvalid/in_tready  hue, saturation, brightness
//  out_*     master     out_tvalid/out_tready red, green, blue
//
//  one transfer is accepted every clock unless all stages are full and the output
//  stalls; an input transfer reaches output valid through the seven register stages
//  stages: hue reduce, sector split, s*f product, reciprocal estimate,
//  quotient fix, value multiply, routing into the output register
//  a stalled output holds the pipeline; empty stages still fill, so
//  in_tready only drops when all seven stages hold pixels
//  rst_n clears the valid bits only; payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_top
  import hsv_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [3*CHAN_W-1:0] in_tdata,   // hue, saturation, brightness
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [3*CHAN_W-1:0]      out_tdata   // red, green, blue
);

  pipe_ctl_t          ctl;
  sector_t            sec_a, sec_b;
  logic [REM_W-1:0]   rem_a;
  logic [CHAN_W-1:0]  sat_a, val_a, pv_a;
  logic [CHAN_W-1:0]  val_b, pv_b, sf_b, sg_b;
  logic [CHAN_W-1:0]  red, green, blue;

  // valid bits and stage enables
  hsv_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .ctl       (ctl)
  );

  // hue reduction, sector, v(1-s)
  hsv_front u_front (
    .clk        (clk),
    .ctl        (ctl),
    .hue        (in_tdata[0 +: HUE_W]),
    .saturation (in_tdata[CHAN_W +: CHAN_W]),
    .brightness (in_tdata[2*CHAN_W +: CHAN_W]),
    .sector     (sec_a),
    .rem        (rem_a),
    .sat        (sat_a),
    .val        (val_a),
    .pv         (pv_a)
  );

  // saturation fractions
  hsv_frac_div u_frac (
    .clk        (clk),
    .ctl        (ctl),
    .sector_in  (sec_a),
    .rem        (rem_a),
    .sat        (sat_a),
    .val_in     (val_a),
    .pv_in      (pv_a),
    .sector_out (sec_b),
    .val_out    (val_b),
    .pv_out     (pv_b),
    .sf         (sf_b),
    .sg         (sg_b)
  );

  // value multiply and routing
  hsv_chan_out u_out (
    .clk    (clk),
    .ctl    (ctl),
    .sector (sec_b),
    .val    (val_b),
    .pv     (pv_b),
    .sf     (sf_b),
    .sg     (sg_b),
    .red    (red),
    .green  (green),
    .blue   (blue)
  );

  assign out_tdata = {blue, green, red};

endmodule

`default_nettype wire
